>>> rtl/task_queue_and_timer_dispatcher_core_assert.svh
// Assertion helpers used by the core RTL.
`ifndef TASK_QUEUE_AND_TIMER_DISPATCHER_CORE_ASSERT_SVH
`define TASK_QUEUE_AND_TIMER_DISPATCHER_CORE_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define TQTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication under the active-low reset.
`define TQTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/tqtd_pkg.sv
`default_nettype none
package tqtd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIMER_SLOTS = 16;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int IDX_W  = $clog2(TIMER_SLOTS + 1);

    localparam int TID_W   = 8;
    localparam int DLY_W   = 16;
    localparam int TICK_W  = 32;
    localparam int QCNT_W  = 5;
    localparam int STAT_W  = 2;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ENQUEUE  = 2'd1,
        OP_SET      = 2'd2,
        OP_DISPATCH = 2'd3
    } t_op;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOSLOT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_SCAN,
        S_SETWR,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [TID_W-1:0] wdata;
    } t_fifo_ctrl;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             empty;
        logic [TID_W-1:0] head;
    } t_fifo_stat;

    typedef struct packed {
        logic [SLOT_W-1:0] idx;
        logic [TID_W-1:0]  key;
        logic              tid_we;
        logic [TID_W-1:0]  tid_wd;
        logic              dly_we;
        logic [DLY_W-1:0]  dly_wd;
    } t_slot_ctrl;

    typedef struct packed {
        logic [TID_W-1:0] tid;
        logic             tid_zero;
        logic             tid_match;
        logic             dly_one;
        logic [DLY_W-1:0] dly_dec;
    } t_slot_stat;

    // The FIFO fill level, at the width reported on the result.
    function automatic logic [QCNT_W-1:0] to_qcount(input logic [CNT_W-1:0] c);
        return QCNT_W'(c);
    endfunction

endpackage
`default_nettype wire

>>> rtl/task_queue_and_timer_dispatcher_core.sv
// Sequence: enqueue and dispatch go from the input transfer through EXEC to RESULT;
// tick walks the slot table after EXEC, set-timer with a nonzero id scans it, then writes in SETWR.
// Throughput: one item at a time, ready again in the cycle after the result is loaded;
// tick and set-timer walk through the slot table one slot per cycle.
// Reset: synchronous, active low; clears the FIFO, the slot ids, the tick count, the FSM.
// No clearing pass: the block is ready in the first cycle after reset.
`default_nettype none
module task_queue_and_timer_dispatcher_core import tqtd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side: [1:0] operation, [9:2] task_id, [25:10] delay, [31:26] zero
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    // master side: [7:0] dispatched_task, [9:8] status, [41:10] tick_count,
    // [46:42] queue_count, [47] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata
);

    t_state r_state, n_state;

    // Captured item.
    t_op              r_op,    n_op;
    logic [TID_W-1:0] r_tid,   n_tid;
    logic [DLY_W-1:0] r_dly,   n_dly;

    // Walk / scan sequencer.
    logic [IDX_W-1:0]  r_idx,        n_idx;
    logic              r_hit_found,  n_hit_found;
    logic [SLOT_W-1:0] r_hit_idx,    n_hit_idx;
    logic              r_free_found, n_free_found;
    logic [SLOT_W-1:0] r_free_idx,   n_free_idx;

    // Architectural state and result.
    logic [TICK_W-1:0] r_ticks,  n_ticks;
    logic [STAT_W-1:0] r_status, n_status;
    logic [TID_W-1:0]  r_disp,   n_disp;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [47:0] r_out_data,  n_out_data;

    t_fifo_ctrl fifo_ctrl;
    t_fifo_stat fifo_stat;
    t_slot_ctrl slot_ctrl;
    t_slot_stat slot_stat;

    logic in_xfer;
    logic out_free;
    logic last_slot;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign last_slot = (r_idx == IDX_W'(TIMER_SLOTS - 1));

    tqtd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (fifo_ctrl),
        .o_stat  (fifo_stat)
    );

    tqtd_slots u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (slot_ctrl),
        .o_stat  (slot_stat)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_TICK: n_state = S_WALK;
                    OP_SET:  n_state = (r_tid == '0) ? S_RESULT : S_SCAN;
                    default: n_state = S_RESULT;
                endcase
            end
            S_WALK: begin
                if (last_slot) begin
                    n_state = S_RESULT;
                end
            end
            S_SCAN: begin
                if (last_slot) begin
                    n_state = S_SETWR;
                end
            end
            S_SETWR: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and unit control.
    always_comb begin
        n_op         = r_op;
        n_tid        = r_tid;
        n_dly        = r_dly;
        n_idx        = r_idx;
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_ticks      = r_ticks;
        n_status     = r_status;
        n_disp       = r_disp;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        fifo_ctrl.push  = 1'b0;
        fifo_ctrl.pop   = 1'b0;
        fifo_ctrl.wdata = r_tid;

        slot_ctrl.idx    = r_idx[SLOT_W-1:0];
        slot_ctrl.key    = r_tid;
        slot_ctrl.tid_we = 1'b0;
        slot_ctrl.tid_wd = r_tid;
        slot_ctrl.dly_we = 1'b0;
        slot_ctrl.dly_wd = r_dly;

        s_axis_tready = (r_state == S_IDLE);

        // Drop the output valid once the downstream side takes the transfer.
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op  = t_op'(s_axis_tdata[1:0]);
                    n_tid = s_axis_tdata[9:2];
                    n_dly = s_axis_tdata[25:10];
                end
            end
            S_EXEC: begin
                n_status     = ST_OK;
                n_disp       = '0;
                n_idx        = '0;
                n_hit_found  = 1'b0;
                n_free_found = 1'b0;
                case (r_op)
                    OP_TICK: begin
                        n_ticks = r_ticks + 1'b1;
                    end
                    OP_ENQUEUE: begin
                        // Idle id is never stored.
                        if (r_tid != '0) begin
                            if (fifo_stat.full) begin
                                n_status = ST_FULL;
                            end else begin
                                fifo_ctrl.push = 1'b1;
                            end
                        end
                    end
                    OP_DISPATCH: begin
                        if (!fifo_stat.empty) begin
                            n_disp        = fifo_stat.head;
                            fifo_ctrl.pop = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                // Count down an occupied slot, or expire it into the FIFO.
                if (!slot_stat.tid_zero) begin
                    if (!slot_stat.dly_one) begin
                        slot_ctrl.dly_we = 1'b1;
                        slot_ctrl.dly_wd = slot_stat.dly_dec;
                    end else begin
                        if (fifo_stat.full) begin
                            n_status = ST_FULL;
                        end else begin
                            fifo_ctrl.push  = 1'b1;
                            fifo_ctrl.wdata = slot_stat.tid;
                        end
                        slot_ctrl.tid_we = 1'b1;
                        slot_ctrl.tid_wd = '0;
                    end
                end
                n_idx = r_idx + 1'b1;
            end
            S_SCAN: begin
                // Record the first slot holding this id and the first free slot.
                if (slot_stat.tid_match && !r_hit_found) begin
                    n_hit_found = 1'b1;
                    n_hit_idx   = r_idx[SLOT_W-1:0];
                end
                if (slot_stat.tid_zero && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx[SLOT_W-1:0];
                end
                n_idx = r_idx + 1'b1;
            end
            S_SETWR: begin
                if (r_hit_found) begin
                    slot_ctrl.idx    = r_hit_idx;
                    slot_ctrl.dly_we = 1'b1;
                end else if (r_free_found) begin
                    slot_ctrl.idx    = r_free_idx;
                    slot_ctrl.tid_we = 1'b1;
                    slot_ctrl.dly_we = 1'b1;
                end else begin
                    n_status = ST_NOSLOT;
                end
            end
            S_RESULT: begin
                // Load the output register once it is empty or being drained.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, to_qcount(fifo_stat.count), r_ticks, r_status, r_disp};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ticks     <= n_ticks;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_tid        <= n_tid;
        r_dly        <= n_dly;
        r_idx        <= n_idx;
        r_hit_found  <= n_hit_found;
        r_hit_idx    <= n_hit_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_status     <= n_status;
        r_disp       <= n_disp;
        r_out_data   <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`include "task_queue_and_timer_dispatcher_core_assert.svh"

    // FIFO level never passes its depth.
    `TQTD_ASSERT_IMPL(a_fifo_level, i_clk, i_rst_n, 1'b1, fifo_stat.count <= CNT_W'(QUEUE_DEPTH))
    // One item at a time: no new transfer right after one is taken.
    `TQTD_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_xfer, !s_axis_tready)
    // Leaving the result state always presents a result.
    `TQTD_ASSERT_NEXT(a_result_out, i_clk, i_rst_n, (r_state == S_RESULT) && out_free, m_axis_tvalid)
    // The walk touches the FIFO by push only.
    `TQTD_ASSERT_IMPL(a_walk_no_pop, i_clk, i_rst_n, r_state == S_WALK, !fifo_ctrl.pop)

endmodule
`default_nettype wire

>>> rtl/tqtd_fifo.sv
`default_nettype none
module tqtd_fifo import tqtd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_fifo_ctrl i_ctrl,
    output t_fifo_stat      o_stat
);

    logic [TID_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_ctrl.push && (r_count != CNT_W'(QUEUE_DEPTH));
    assign do_pop  = i_ctrl.pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_ctrl.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                r_count  <= r_count + 1'b1;
            end else if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
                r_count  <= r_count - 1'b1;
            end
        end
    end

    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.head  = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

>>> rtl/tqtd_slots.sv
`default_nettype none
module tqtd_slots import tqtd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_slot_ctrl i_ctrl,
    output t_slot_stat      o_stat
);

    logic [TID_W-1:0] r_tid [TIMER_SLOTS];
    logic [DLY_W-1:0] r_dly [TIMER_SLOTS];

    logic [TID_W-1:0] rd_tid;
    logic [DLY_W-1:0] rd_dly;

    // Free slots hold id zero; clear the ids at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                r_tid[i] <= '0;
            end
        end else if (i_ctrl.tid_we) begin
            r_tid[i_ctrl.idx] <= i_ctrl.tid_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.dly_we) begin
            r_dly[i_ctrl.idx] <= i_ctrl.dly_wd;
        end
    end

    // Shared compare and decrement unit on the addressed slot.
    assign rd_tid = r_tid[i_ctrl.idx];
    assign rd_dly = r_dly[i_ctrl.idx];

    assign o_stat.tid       = rd_tid;
    assign o_stat.tid_zero  = (rd_tid == '0);
    assign o_stat.tid_match = (rd_tid == i_ctrl.key);
    assign o_stat.dly_one   = (rd_dly == DLY_W'(1));
    assign o_stat.dly_dec   = rd_dly - DLY_W'(1);

endmodule
`default_nettype wire
